[rtl/quad_area_3d_unit_assert.svh]
// assertion macros for the quad area unit
`ifndef QUAD_AREA_3D_UNIT_ASSERT_SVH
`define QUAD_AREA_3D_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QA_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QA_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QA_ASSERT_IMPL(label, clk, rst, prop, msg)
`define QA_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[rtl/qa3d_pkg.sv]
`default_nettype none
package qa3d_pkg;
  localparam int COORD_BITS = 16;
  localparam int AREA_BITS  = 33;
  localparam int QUAD_BITS  = 34;
  // edge vectors are one bit wider than coordinates
  localparam int DIFF_BITS  = COORD_BITS + 1;
  // one product term, then a cross component
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int MAG_BITS   = CROSS_BITS - 1;
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;
  // root width: one bit per pair of radicand bits
  localparam int ROOT_BITS  = SUM_BITS / 2;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int HALF_MUL   = MAG_BITS / 2 + MAG_BITS % 2;
  localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
    logic signed [COORD_BITS-1:0] d_x;
    logic signed [COORD_BITS-1:0] d_y;
    logic signed [COORD_BITS-1:0] d_z;
  } in_item_t;

  typedef struct packed {
    logic [AREA_BITS-1:0] area_abc;
    logic [AREA_BITS-1:0] area_acd;
    logic [QUAD_BITS-1:0] area_quad;
  } out_item_t;

  // data handed from one root cell to the next
  typedef struct packed {
    logic                  vld;
    logic [SUM_BITS-1:0]   rad;
    logic [REM_BITS-1:0]   rem;
    logic [ROOT_BITS-1:0]  root;
  } root_lane_t;
endpackage
`default_nettype wire

[rtl/quad_area_3d_unit.sv]
`default_nettype none
// quad area unit: splits quad a b c d along a-c, outputs both triangle areas
// and their sum, all unsigned with 16 fraction bits.
// channels: in_valid/in_ready carry one in_item_t request of twelve Q8.8
// corner coordinates; out_valid/out_ready carry one out_item_t result.
// pipeline: 7 front end stages (edges, products, cross, magnitude, partial
// squares, squares, sum), one stage per root bit in the chain of root cells,
// then one output stage.
// throughput: one request per cycle unless frozen; the pipeline moves as one.
// when out_ready is low with a result held, the pipeline freezes and
// in_ready drops; a free output register keeps the pipe moving.
// reset clears all valid flags; no result is shown until a request enters.
module quad_area_3d_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire qa3d_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output qa3d_pkg::out_item_t out_data
);
`include "quad_area_3d_unit_assert.svh"
  localparam int CB = qa3d_pkg::COORD_BITS;
  localparam int TB = qa3d_pkg::ROOT_BITS;
  localparam int FE = 7;

  logic en;
  logic signed [CB-1:0] pa [3];
  logic signed [CB-1:0] pb [3];
  logic signed [CB-1:0] pc [3];
  logic signed [CB-1:0] pd [3];
  logic [qa3d_pkg::SUM_BITS-1:0] sum_abc, sum_acd;
  logic [FE-1:0] fe_vld;
  qa3d_pkg::root_lane_t lane_abc [TB+1];
  qa3d_pkg::root_lane_t lane_acd [TB+1];
  logic [qa3d_pkg::AREA_BITS-1:0] area_abc_w, area_acd_w;

  // pipeline moves unless a result is held at the output
  assign en = out_ready || !out_valid;
  assign in_ready = en;

  assign pa = '{in_data.a_x, in_data.a_y, in_data.a_z};
  assign pb = '{in_data.b_x, in_data.b_y, in_data.b_z};
  assign pc = '{in_data.c_x, in_data.c_y, in_data.c_z};
  assign pd = '{in_data.d_x, in_data.d_y, in_data.d_z};

  qa3d_tri u_tri_abc (.clk(clk), .en(en), .p(pa), .q(pb), .r(pc), .sum(sum_abc));
  qa3d_tri u_tri_acd (.clk(clk), .en(en), .p(pa), .q(pc), .r(pd), .sum(sum_acd));

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_vld <= '0;
    end else if (en) begin
      fe_vld <= {fe_vld[FE-2:0], in_valid};
    end
  end

  assign lane_abc[0] = '{vld: fe_vld[FE-1], rad: sum_abc, rem: '0, root: '0};
  assign lane_acd[0] = '{vld: fe_vld[FE-1], rad: sum_acd, rem: '0, root: '0};

  for (genvar k = 0; k < TB; k++) begin : g_root
    qa3d_root_cell u_cell_abc (
      .clk(clk), .rst(rst), .en(en), .lane_in(lane_abc[k]), .lane_out(lane_abc[k+1])
    );
    qa3d_root_cell u_cell_acd (
      .clk(clk), .rst(rst), .en(en), .lane_in(lane_acd[k]), .lane_out(lane_acd[k+1])
    );
  end

  // halve the root, saturate to the area width
  always_comb begin
    area_abc_w = (lane_abc[TB].root[TB-1:1] > TB'(qa3d_pkg::AREA_MAX))
               ? qa3d_pkg::AREA_MAX
               : qa3d_pkg::AREA_BITS'(lane_abc[TB].root[TB-1:1]);
    area_acd_w = (lane_acd[TB].root[TB-1:1] > TB'(qa3d_pkg::AREA_MAX))
               ? qa3d_pkg::AREA_MAX
               : qa3d_pkg::AREA_BITS'(lane_acd[TB].root[TB-1:1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= lane_abc[TB].vld;
    end
    if (en) begin
      out_data.area_abc  <= area_abc_w;
      out_data.area_acd  <= area_acd_w;
      out_data.area_quad <= qa3d_pkg::QUAD_BITS'(area_abc_w)
                          + qa3d_pkg::QUAD_BITS'(area_acd_w);
    end
  end

  `QA_ASSERT_IMPL(a_lanes_agree, clk, rst, lane_abc[TB].vld == lane_acd[TB].vld, "lanes disagree")
  `QA_ASSERT_IMPL(a_hold, clk, rst, (out_valid && !out_ready) |=> out_valid && $stable(out_data), "result lost under stall")
  `QA_ASSERT_IMPL(a_sum, clk, rst, out_valid |-> out_data.area_quad == qa3d_pkg::QUAD_BITS'(out_data.area_abc) + qa3d_pkg::QUAD_BITS'(out_data.area_acd), "sum wrong")
  `QA_ASSERT_RST(a_reset, clk, rst |=> !out_valid, "valid after reset")
endmodule
`default_nettype wire

[rtl/qa3d_tri.sv]
`default_nettype none
// triangle front end: edges, cross product, sum of squares, all pipelined
module qa3d_tri (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [qa3d_pkg::COORD_BITS-1:0] p [3],
  input  wire logic signed [qa3d_pkg::COORD_BITS-1:0] q [3],
  input  wire logic signed [qa3d_pkg::COORD_BITS-1:0] r [3],
  output logic [qa3d_pkg::SUM_BITS-1:0] sum
);
  localparam int DB = qa3d_pkg::DIFF_BITS;
  localparam int PB = qa3d_pkg::PROD_BITS;
  localparam int CB = qa3d_pkg::CROSS_BITS;
  localparam int MB = qa3d_pkg::MAG_BITS;
  localparam int SB = qa3d_pkg::SQ_BITS;
  localparam int HB = qa3d_pkg::HALF_MUL;

  logic signed [DB-1:0] u [3];
  logic signed [DB-1:0] v [3];
  logic signed [PB-1:0] prod [6];
  logic signed [CB-1:0] cr [3];
  logic [MB-1:0] mag [3];
  logic [2*HB-1:0] pp_hh [3];
  logic [2*HB-1:0] pp_hl [3];
  logic [2*HB-1:0] pp_ll [3];
  logic [SB-1:0] sq [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u[i] <= DB'(q[i]) - DB'(p[i]);
        v[i] <= DB'(r[i]) - DB'(p[i]);
      end
      prod[0] <= PB'(u[1]) * PB'(v[2]);
      prod[1] <= PB'(u[2]) * PB'(v[1]);
      prod[2] <= PB'(u[2]) * PB'(v[0]);
      prod[3] <= PB'(u[0]) * PB'(v[2]);
      prod[4] <= PB'(u[0]) * PB'(v[1]);
      prod[5] <= PB'(u[1]) * PB'(v[0]);
      for (int i = 0; i < 3; i++) begin
        cr[i] <= CB'(prod[2*i]) - CB'(prod[2*i+1]);
        mag[i] <= cr[i][CB-1] ? MB'(-cr[i]) : MB'(cr[i]);
        // square split into half-width partial products
        pp_hh[i] <= (2*HB)'(mag[i][MB-1:HB]) * (2*HB)'(mag[i][MB-1:HB]);
        pp_hl[i] <= (2*HB)'(mag[i][MB-1:HB]) * (2*HB)'(mag[i][HB-1:0]);
        pp_ll[i] <= (2*HB)'(mag[i][HB-1:0]) * (2*HB)'(mag[i][HB-1:0]);
        sq[i] <= (SB'(pp_hh[i]) << (2*HB)) + (SB'(pp_hl[i]) << (HB+1))
               + SB'(pp_ll[i]);
      end
      sum <= qa3d_pkg::SUM_BITS'(sq[0]) + qa3d_pkg::SUM_BITS'(sq[1])
           + qa3d_pkg::SUM_BITS'(sq[2]);
    end
  end
endmodule
`default_nettype wire

[rtl/qa3d_root_cell.sv]
`default_nettype none
// one restoring square root step: brings down two radicand bits
module qa3d_root_cell (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire qa3d_pkg::root_lane_t lane_in,
  output qa3d_pkg::root_lane_t lane_out
);
  localparam int RB = qa3d_pkg::REM_BITS;
  localparam int SB = qa3d_pkg::SUM_BITS;
  localparam int TB = qa3d_pkg::ROOT_BITS;
  logic [RB-1:0] trial_rem;
  logic [RB-1:0] trial_sub;
  logic          fits;

  always_comb begin
    trial_rem = {lane_in.rem[RB-3:0], lane_in.rad[SB-1:SB-2]};
    trial_sub = {lane_in.root, 2'b01};
    fits = trial_rem >= trial_sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.vld <= 1'b0;
    end else if (en) begin
      lane_out.vld <= lane_in.vld;
    end
    if (en) begin
      lane_out.rad  <= {lane_in.rad[SB-3:0], 2'b00};
      lane_out.rem  <= fits ? trial_rem - trial_sub : trial_rem;
      lane_out.root <= {lane_in.root[TB-2:0], fits};
    end
  end
endmodule
`default_nettype wire
